@@ design/msmhd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msmhd_pkg
// Types, field positions and helper functions shared by the MSM header
// decoder modules.
// ----------------------------------------------------------------------------
package msmhd_pkg;

    localparam int unsigned MinBytes      = 22;
    localparam int unsigned PosMax        = 4095;
    localparam int unsigned MsgNumEnd     = 11;
    localparam int unsigned StationEnd    = 23;
    localparam int unsigned DayEnd        = 26;
    localparam int unsigned EpochEnd      = 53;
    localparam int unsigned GloEpochBits  = 27;
    localparam int unsigned FlagMultiPos  = 54;
    localparam int unsigned SmoothEnd     = 72;
    localparam int unsigned SatMaskFirst  = 73;
    localparam int unsigned SatMaskEnd    = 136;
    localparam int unsigned SigMaskFirst  = 137;
    localparam int unsigned SigMaskEnd    = 168;
    localparam int unsigned HdrBits       = 169;
    localparam int unsigned CellLimitByte = SigMaskEnd / 8;
    localparam int unsigned GpsFirstMsg   = 1071;
    localparam int unsigned MsgStride     = 10;
    localparam int unsigned MsgSpan       = 6;
    localparam int unsigned NumSystems    = 7;
    localparam int unsigned Recip10       = 3277;
    localparam int unsigned Recip10Shift  = 15;

    typedef enum logic [2:0] {
        CONST_GPS     = 3'd0,
        CONST_GLONASS = 3'd1,
        CONST_GALILEO = 3'd2,
        CONST_SBAS    = 3'd3,
        CONST_QZSS    = 3'd4,
        CONST_BEIDOU  = 3'd5,
        CONST_NAVIC   = 3'd6,
        CONST_UNKNOWN = 3'd7
    } constellation_t;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_NEED_DATA = 1'b1
    } status_t;

    typedef struct packed {
        status_t        status;
        constellation_t constellation;
        logic [3:0]     msm_level;
        logic [11:0]    station;
        logic [2:0]     glo_day;
        logic [29:0]    epoch_msec;
        logic [4:0]     flag_bits;
        logic [63:0]    sat_mask;
        logic [31:0]    signal_mask;
        logic [6:0]     sat_total;
        logic [5:0]     sig_total;
        logic [11:0]    cell_count;
    } result_t;

    function automatic constellation_t constellation_of(input logic [11:0] m);
        logic [11:0]    base;
        constellation_t res;
        res = CONST_UNKNOWN;
        for (int c = 0; c < NumSystems; c++) begin
            base = 12'(GpsFirstMsg + MsgStride * c);
            if (m >= base && m <= 12'(base + MsgSpan)) begin
                res = constellation_t'(3'(c));
            end
        end
        return res;
    endfunction

    // remainder by ten through a reciprocal multiply, exact for 12-bit values
    function automatic logic [3:0] mod10(input logic [11:0] x);
        logic [23:0] prod;
        logic [11:0] q;
        logic [11:0] r;
        prod = 24'(x) * 24'(Recip10);
        q    = 12'(prod >> Recip10Shift);
        r    = x - ((q << 3) + (q << 1));
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

@@ design/msmhd_parse.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msmhd_parse
// Byte-wide header parser: places the eight bits of each body byte into the
// header fields, keeps the mask and cell counts, and forms the result on the
// last byte of a body.
// ----------------------------------------------------------------------------
module msmhd_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output msmhd_pkg::result_t     res
);

    logic [11:0] bit_pos_reg, bit_pos_upd, bit_pos_next;
    logic [4:0]  byte_cnt_reg, byte_cnt_upd, byte_cnt_next;
    logic [11:0] msg_num_reg, msg_num_upd, msg_num_next;
    logic [11:0] station_reg, station_upd, station_next;
    logic [29:0] epoch_reg, epoch_upd, epoch_next;
    logic [2:0]  day_reg, day_upd, day_next;
    logic [4:0]  flags_reg, flags_upd, flags_next;
    logic [63:0] sat_mask_reg, sat_mask_upd, sat_mask_next;
    logic [31:0] sig_mask_reg, sig_mask_upd, sig_mask_next;
    logic [6:0]  sat_cnt_reg, sat_cnt_upd, sat_cnt_next;
    logic [5:0]  sig_cnt_reg, sig_cnt_upd, sig_cnt_next;
    logic [11:0] cell_limit_reg, cell_limit_upd, cell_limit_next;
    logic [11:0] cell_ones_reg, cell_ones_upd, cell_ones_next;

    logic [8:0]                byte_idx;
    logic                      is_glonass;
    msmhd_pkg::constellation_t sys;
    logic [5:0]                sig_final;
    logic [12:0]               cell_prod;
    logic [11:0]               cell_limit_fresh;
    logic [3:0]                sat_add, sig_add, cell_add;
    logic                      need_data;

    assign byte_idx   = bit_pos_reg[11:3];
    assign sys        = msmhd_pkg::constellation_of(msg_num_reg);
    assign is_glonass = (sys == msmhd_pkg::CONST_GLONASS);

    // cell mask length becomes known on the last signal mask bit
    assign sig_final        = sig_cnt_reg + 6'(in_byte[7]);
    assign cell_prod        = 13'(sat_cnt_reg) * 13'(sig_final);
    assign cell_limit_fresh = 12'(msmhd_pkg::HdrBits) + cell_prod[11:0];

    // fixed-position fields
    always_comb begin
        logic [11:0] pos;
        msg_num_upd  = msg_num_reg;
        station_upd  = station_reg;
        epoch_upd    = epoch_reg;
        day_upd      = day_reg;
        flags_upd    = flags_reg;
        sat_mask_upd = sat_mask_reg;
        sig_mask_upd = sig_mask_reg;
        for (int i = 0; i < 12; i++) begin
            pos = 12'(msmhd_pkg::MsgNumEnd - i);
            if (byte_idx == pos[11:3]) begin
                msg_num_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
            pos = 12'(msmhd_pkg::StationEnd - i);
            if (byte_idx == pos[11:3]) begin
                station_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
        for (int i = 0; i < 30; i++) begin
            pos = 12'(msmhd_pkg::EpochEnd - i);
            if (byte_idx == pos[11:3] && !(is_glonass && i >= msmhd_pkg::GloEpochBits)) begin
                epoch_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
        for (int i = 0; i < 3; i++) begin
            pos = 12'(msmhd_pkg::DayEnd - i);
            if (byte_idx == pos[11:3] && is_glonass) begin
                day_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
        pos = 12'(msmhd_pkg::FlagMultiPos);
        if (byte_idx == pos[11:3]) begin
            flags_upd[4] = in_byte[3'd7 - pos[2:0]];
        end
        for (int i = 0; i < 4; i++) begin
            pos = 12'(msmhd_pkg::SmoothEnd - i);
            if (byte_idx == pos[11:3]) begin
                flags_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
        for (int i = 0; i < 64; i++) begin
            pos = 12'(msmhd_pkg::SatMaskEnd - i);
            if (byte_idx == pos[11:3]) begin
                sat_mask_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
        for (int i = 0; i < 32; i++) begin
            pos = 12'(msmhd_pkg::SigMaskEnd - i);
            if (byte_idx == pos[11:3]) begin
                sig_mask_upd[i] = in_byte[3'd7 - pos[2:0]];
            end
        end
    end

    // per-byte counts of mask and cell bits
    always_comb begin
        logic [11:0] p;
        logic        b;
        sat_add = '0;
        sig_add = '0;
        cell_add = '0;
        cell_limit_upd = (byte_idx == 9'(msmhd_pkg::CellLimitByte)) ? cell_limit_fresh
                                                                    : cell_limit_reg;
        for (int k = 0; k < 8; k++) begin
            p = {byte_idx, 3'(k)};
            b = in_byte[7 - k];
            if (p >= 12'(msmhd_pkg::SatMaskFirst) && p <= 12'(msmhd_pkg::SatMaskEnd)) begin
                sat_add = sat_add + 4'(b);
            end
            if (p >= 12'(msmhd_pkg::SigMaskFirst) && p <= 12'(msmhd_pkg::SigMaskEnd)) begin
                sig_add = sig_add + 4'(b);
            end
            if (p >= 12'(msmhd_pkg::HdrBits) && p < cell_limit_upd) begin
                cell_add = cell_add + 4'(b);
            end
        end
    end

    assign sat_cnt_upd   = sat_cnt_reg + 7'(sat_add);
    assign sig_cnt_upd   = sig_cnt_reg + 6'(sig_add);
    assign cell_ones_upd = cell_ones_reg + 12'(cell_add);
    assign bit_pos_upd   = (bit_pos_reg > 12'(msmhd_pkg::PosMax - 8)) ? 12'(msmhd_pkg::PosMax)
                                                                      : bit_pos_reg + 12'd8;
    assign byte_cnt_upd  = (byte_cnt_reg < 5'(msmhd_pkg::MinBytes)) ? byte_cnt_reg + 5'd1
                                                                    : byte_cnt_reg;

    // a finished body starts the next one from the cleared state
    always_comb begin
        if (in_last) begin
            bit_pos_next    = '0;
            byte_cnt_next   = '0;
            msg_num_next    = '0;
            station_next    = '0;
            epoch_next      = '0;
            day_next        = '0;
            flags_next      = '0;
            sat_mask_next   = '0;
            sig_mask_next   = '0;
            sat_cnt_next    = '0;
            sig_cnt_next    = '0;
            cell_limit_next = 12'(msmhd_pkg::HdrBits);
            cell_ones_next  = '0;
        end else begin
            bit_pos_next    = bit_pos_upd;
            byte_cnt_next   = byte_cnt_upd;
            msg_num_next    = msg_num_upd;
            station_next    = station_upd;
            epoch_next      = epoch_upd;
            day_next        = day_upd;
            flags_next      = flags_upd;
            sat_mask_next   = sat_mask_upd;
            sig_mask_next   = sig_mask_upd;
            sat_cnt_next    = sat_cnt_upd;
            sig_cnt_next    = sig_cnt_upd;
            cell_limit_next = cell_limit_upd;
            cell_ones_next  = cell_ones_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg    <= '0;
            byte_cnt_reg   <= '0;
            msg_num_reg    <= '0;
            station_reg    <= '0;
            epoch_reg      <= '0;
            day_reg        <= '0;
            flags_reg      <= '0;
            sat_mask_reg   <= '0;
            sig_mask_reg   <= '0;
            sat_cnt_reg    <= '0;
            sig_cnt_reg    <= '0;
            cell_limit_reg <= 12'(msmhd_pkg::HdrBits);
            cell_ones_reg  <= '0;
        end else if (take) begin
            bit_pos_reg    <= bit_pos_next;
            byte_cnt_reg   <= byte_cnt_next;
            msg_num_reg    <= msg_num_next;
            station_reg    <= station_next;
            epoch_reg      <= epoch_next;
            day_reg        <= day_next;
            flags_reg      <= flags_next;
            sat_mask_reg   <= sat_mask_next;
            sig_mask_reg   <= sig_mask_next;
            sat_cnt_reg    <= sat_cnt_next;
            sig_cnt_reg    <= sig_cnt_next;
            cell_limit_reg <= cell_limit_next;
            cell_ones_reg  <= cell_ones_next;
        end
    end

    // result for a body ending with this byte
    assign need_data = (byte_cnt_upd < 5'(msmhd_pkg::MinBytes)) ||
                       (bit_pos_upd < cell_limit_upd);

    always_comb begin
        res = '0;
        if (need_data) begin
            res.status = msmhd_pkg::STATUS_NEED_DATA;
        end else begin
            res.status        = msmhd_pkg::STATUS_OK;
            res.constellation = sys;
            res.msm_level     = msmhd_pkg::mod10(msg_num_reg);
            res.station       = station_upd;
            res.glo_day       = is_glonass ? day_upd : 3'd0;
            res.epoch_msec    = is_glonass ? {3'd0, epoch_upd[26:0]} : epoch_upd;
            res.flag_bits     = flags_upd;
            res.sat_mask      = sat_mask_upd;
            res.signal_mask   = sig_mask_upd;
            res.sat_total     = sat_cnt_upd;
            res.sig_total     = sig_cnt_upd;
            res.cell_count    = cell_ones_upd;
        end
    end

endmodule
`default_nettype wire

@@ design/msm_header_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msm_header_decoder
// Streaming decoder for the fixed header of an MSM correction message body.
// ----------------------------------------------------------------------------
// One body byte is taken per clock, most significant bit first, and all eight
// bits are placed into the header fields in that same cycle, so the decoder
// sustains one item per cycle. The result for a body appears on the m_ port
// the cycle after its last byte is accepted and is held until taken; bytes
// that do not end a body are accepted even while a result waits, and only a
// last byte stalls behind an untaken result. There is no start-up clearing
// pass: the decoder is ready right after reset. Bodies shorter than 22 bytes,
// or too short for their cell mask, report need-data with all other fields
// zero; bytes beyond the cell mask are ignored.
module msm_header_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_body_byte,
    input  wire logic        s_body_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [2:0]       m_constellation,
    output logic [3:0]       m_msm_level,
    output logic [11:0]      m_station,
    output logic [2:0]       m_glo_day,
    output logic [29:0]      m_epoch_msec,
    output logic [4:0]       m_flag_bits,
    output logic [63:0]      m_sat_mask,
    output logic [31:0]      m_signal_mask,
    output logic [6:0]       m_sat_total,
    output logic [5:0]       m_sig_total,
    output logic [11:0]      m_cell_count
);

    msmhd_pkg::result_t parse_res;
    msmhd_pkg::result_t res_reg;
    logic               m_valid_reg, m_valid_next;
    logic               take;
    logic               emit;

    assign s_ready = !m_valid_reg || m_ready || !s_body_last;
    assign take    = s_valid && s_ready;
    assign emit    = take && s_body_last;

    msmhd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_byte (s_body_byte),
        .in_last (s_body_last),
        .res     (parse_res)
    );

    always_comb begin
        priority if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= parse_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = res_reg.status;
    assign m_constellation = res_reg.constellation;
    assign m_msm_level     = res_reg.msm_level;
    assign m_station       = res_reg.station;
    assign m_glo_day       = res_reg.glo_day;
    assign m_epoch_msec    = res_reg.epoch_msec;
    assign m_flag_bits     = res_reg.flag_bits;
    assign m_sat_mask      = res_reg.sat_mask;
    assign m_signal_mask   = res_reg.signal_mask;
    assign m_sat_total     = res_reg.sat_total;
    assign m_sig_total     = res_reg.sig_total;
    assign m_cell_count    = res_reg.cell_count;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for msm_header_decoder. MSM bodies are streamed in one
// byte per item. A bit-level model of the header parser predicts the result
// of every body, and each result taken from the m_ channel is compared with
// that prediction field by field. Both sides of the bench idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SmoothFirst    = msmhd_pkg::SmoothEnd - 3;
    localparam int unsigned MsmLevels      = 10;
    localparam int unsigned SaturatedBytes = 516;
    localparam int unsigned PhaseBodies    = 9;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_body_byte = 8'h00;
    logic        s_body_last = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_status;
    logic [2:0]  m_constellation;
    logic [3:0]  m_msm_level;
    logic [11:0] m_station;
    logic [2:0]  m_glo_day;
    logic [29:0] m_epoch_msec;
    logic [4:0]  m_flag_bits;
    logic [63:0] m_sat_mask;
    logic [31:0] m_signal_mask;
    logic [6:0]  m_sat_total;
    logic [5:0]  m_sig_total;
    logic [11:0] m_cell_count;

    msm_header_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_body_byte     (s_body_byte),
        .s_body_last     (s_body_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_constellation (m_constellation),
        .m_msm_level     (m_msm_level),
        .m_station       (m_station),
        .m_glo_day       (m_glo_day),
        .m_epoch_msec    (m_epoch_msec),
        .m_flag_bits     (m_flag_bits),
        .m_sat_mask      (m_sat_mask),
        .m_signal_mask   (m_signal_mask),
        .m_sat_total     (m_sat_total),
        .m_sig_total     (m_sig_total),
        .m_cell_count    (m_cell_count)
    );

    always #5 aclk = ~aclk;

    // parser model state
    int unsigned dec_pos;
    int unsigned dec_bytes;
    logic [11:0] dec_msg;
    logic [11:0] dec_station;
    logic [29:0] dec_epoch;
    logic [2:0]  dec_day;
    logic [4:0]  dec_flags;
    logic [63:0] dec_sat_mask;
    logic [31:0] dec_sig_mask;
    int unsigned dec_sats;
    int unsigned dec_sigs;
    int unsigned dec_cell_len;
    int unsigned dec_cell_ones;
    msmhd_pkg::result_t expected_headers[$];

    logic [7:0]  body_q[$];
    bit          body_bits[$];
    int unsigned body_cells;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;

    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned bodies_sent    = 0;
    int unsigned headers_ok     = 0;
    int unsigned headers_short  = 0;
    int unsigned glonass_ok     = 0;

    function automatic msmhd_pkg::constellation_t msm_system(input logic [11:0] msg);
        int unsigned offset;
        offset = msg - msmhd_pkg::GpsFirstMsg;
        if (msg >= msmhd_pkg::GpsFirstMsg
                && offset < msmhd_pkg::NumSystems * msmhd_pkg::MsgStride
                && offset % msmhd_pkg::MsgStride <= msmhd_pkg::MsgSpan) begin
            return msmhd_pkg::constellation_t'(3'(offset / msmhd_pkg::MsgStride));
        end
        return msmhd_pkg::CONST_UNKNOWN;
    endfunction

    task automatic clear_decoder();
        dec_pos       = 0;
        dec_bytes     = 0;
        dec_msg       = '0;
        dec_station   = '0;
        dec_epoch     = '0;
        dec_day       = '0;
        dec_flags     = '0;
        dec_sat_mask  = '0;
        dec_sig_mask  = '0;
        dec_sats      = 0;
        dec_sigs      = 0;
        dec_cell_len  = 0;
        dec_cell_ones = 0;
    endtask

    task automatic absorb_bit(input int unsigned p, input logic b);
        if (p <= msmhd_pkg::MsgNumEnd) begin
            dec_msg = {dec_msg[10:0], b};
        end else if (p <= msmhd_pkg::StationEnd) begin
            dec_station = {dec_station[10:0], b};
        end else if (p <= msmhd_pkg::EpochEnd) begin
            if (p <= msmhd_pkg::DayEnd && msm_system(dec_msg) == msmhd_pkg::CONST_GLONASS) begin
                dec_day = {dec_day[1:0], b};
            end else begin
                dec_epoch = {dec_epoch[28:0], b};
            end
        end else if (p == msmhd_pkg::FlagMultiPos) begin
            dec_flags[4] = b;
        end else if (p >= SmoothFirst && p <= msmhd_pkg::SmoothEnd) begin
            dec_flags[3:0] = {dec_flags[2:0], b};
        end else if (p >= msmhd_pkg::SatMaskFirst && p <= msmhd_pkg::SatMaskEnd) begin
            dec_sat_mask = {dec_sat_mask[62:0], b};
            dec_sats += 32'(b);
        end else if (p >= msmhd_pkg::SigMaskFirst && p <= msmhd_pkg::SigMaskEnd) begin
            dec_sig_mask = {dec_sig_mask[30:0], b};
            dec_sigs += 32'(b);
            if (p == msmhd_pkg::SigMaskEnd) begin
                dec_cell_len = dec_sats * dec_sigs;
            end
        end else if (p >= msmhd_pkg::HdrBits && p < msmhd_pkg::HdrBits + dec_cell_len) begin
            dec_cell_ones += 32'(b);
        end
    endtask

    task automatic predict_byte(input logic [7:0] data_byte, input logic is_last);
        msmhd_pkg::result_t hdr;
        for (int k = 0; k < 8; k++) begin
            if (dec_pos + k < msmhd_pkg::PosMax) begin
                absorb_bit(dec_pos + k, data_byte[7 - k]);
            end
        end
        dec_pos = (dec_pos + 8 > msmhd_pkg::PosMax) ? msmhd_pkg::PosMax : dec_pos + 8;
        if (dec_bytes < msmhd_pkg::MinBytes) begin
            dec_bytes++;
        end
        if (is_last) begin
            hdr = '0;
            if (dec_bytes < msmhd_pkg::MinBytes
                    || dec_pos < msmhd_pkg::HdrBits + dec_cell_len) begin
                hdr.status = msmhd_pkg::STATUS_NEED_DATA;
            end else begin
                hdr.status        = msmhd_pkg::STATUS_OK;
                hdr.constellation = msm_system(dec_msg);
                hdr.msm_level     = 4'(dec_msg % MsmLevels);
                hdr.station       = dec_station;
                hdr.flag_bits     = dec_flags;
                hdr.sat_mask      = dec_sat_mask;
                hdr.signal_mask   = dec_sig_mask;
                hdr.sat_total     = 7'(dec_sats);
                hdr.sig_total     = 6'(dec_sigs);
                hdr.cell_count    = 12'(dec_cell_ones);
                if (hdr.constellation == msmhd_pkg::CONST_GLONASS) begin
                    hdr.glo_day    = dec_day;
                    hdr.epoch_msec = {3'b000, dec_epoch[msmhd_pkg::GloEpochBits-1:0]};
                end else begin
                    hdr.epoch_msec = dec_epoch;
                end
            end
            expected_headers.push_back(hdr);
            clear_decoder();
        end
    endtask

    task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_body_byte <= data_byte;
        s_body_last <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(data_byte, is_last);
        bytes_sent++;
    endtask

    task automatic send_body();
        foreach (body_q[i]) begin
            send_byte(body_q[i], i == body_q.size() - 1);
        end
        bodies_sent++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_headers.size() != 0);
    endtask

    function automatic void push_bits(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            body_bits.push_back(v[i]);
        end
    endfunction

    // full header, random station, epoch and flags, the whole cell mask
    function automatic void build_body(input logic [11:0] msg, input logic [63:0] sats,
                                       input logic [31:0] sigs, input int trailing);
        logic [7:0] b;
        body_cells = $countones(sats) * $countones(sigs);
        body_bits.delete();
        body_q.delete();
        push_bits(64'(msg), 12);
        push_bits(64'($urandom_range(0, 4095)), 12);
        push_bits({$urandom, $urandom}, msmhd_pkg::SatMaskFirst - 24);
        push_bits(sats, 64);
        push_bits(64'(sigs), 32);
        for (int i = 0; i < body_cells; i++) begin
            body_bits.push_back(1'($urandom_range(0, 1)));
        end
        while (body_bits.size() % 8 != 0) begin
            body_bits.push_back(1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < body_bits.size(); i += 8) begin
            for (int k = 0; k < 8; k++) begin
                b[7 - k] = body_bits[i + k];
            end
            body_q.push_back(b);
        end
        repeat (trailing) body_q.push_back(8'($urandom));
    endfunction

    function automatic logic [63:0] sparse_mask(input int unsigned width,
                                                input int unsigned ones);
        logic [63:0] m;
        m = '0;
        repeat (ones) m[$urandom_range(0, width - 1)] = 1'b1;
        return m;
    endfunction

    function automatic logic [11:0] pick_msg();
        int unsigned base;
        base = msmhd_pkg::GpsFirstMsg
             + msmhd_pkg::MsgStride * $urandom_range(0, msmhd_pkg::NumSystems - 1);
        case ($urandom_range(0, 4))
            0: return 12'(base);
            1: return 12'(base + msmhd_pkg::MsgSpan);
            2: return 12'(base + $urandom_range(0, msmhd_pkg::MsgSpan));
            3: return $urandom_range(0, 1) ? 12'(base - 1)
                                           : 12'(base + msmhd_pkg::MsgSpan + 1);
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // receiver, with long hold-offs on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        msmhd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_headers.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no body pending, status %0b", $time, m_status);
            end else begin
                want = expected_headers.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("constellation", 64'(want.constellation), 64'(m_constellation));
                check_field("msm_level", 64'(want.msm_level), 64'(m_msm_level));
                check_field("station", 64'(want.station), 64'(m_station));
                check_field("glo_day", 64'(want.glo_day), 64'(m_glo_day));
                check_field("epoch_msec", 64'(want.epoch_msec), 64'(m_epoch_msec));
                check_field("flag_bits", 64'(want.flag_bits), 64'(m_flag_bits));
                check_field("sat_mask", want.sat_mask, m_sat_mask);
                check_field("signal_mask", 64'(want.signal_mask), 64'(m_signal_mask));
                check_field("sat_total", 64'(want.sat_total), 64'(m_sat_total));
                check_field("sig_total", 64'(want.sig_total), 64'(m_sig_total));
                check_field("cell_count", 64'(want.cell_count), 64'(m_cell_count));
                if (want.status == msmhd_pkg::STATUS_OK) begin
                    headers_ok++;
                    if (want.constellation == msmhd_pkg::CONST_GLONASS) begin
                        glonass_ok++;
                    end
                end else begin
                    headers_short++;
                end
            end
        end
    end

    task automatic test_short_bodies();
        body_q = '{8'hFF};
        send_body();
        body_q.delete();
        for (int i = 0; i < msmhd_pkg::MinBytes - 1; i++) begin
            body_q.push_back(i[0] ? 8'hFF : 8'h00);
        end
        send_body();
        wait_results();
    endtask

    task automatic test_header_extremes();
        body_q.delete();
        repeat (msmhd_pkg::MinBytes) body_q.push_back(8'h00);
        send_body();
        // all ones asks for a full cell mask that is not there
        body_q.delete();
        repeat (msmhd_pkg::MinBytes) body_q.push_back(8'hFF);
        send_body();
        build_body(12'(msmhd_pkg::GpsFirstMsg + msmhd_pkg::MsgStride + msmhd_pkg::MsgSpan),
                   '1, 32'h8000_0000, 0);
        send_body();
        wait_results();
    endtask

    // largest cell mask, then enough bytes to pin the bit counter
    task automatic test_saturated_body();
        build_body(12'(msmhd_pkg::GpsFirstMsg
                       + msmhd_pkg::MsgStride * (msmhd_pkg::NumSystems - 1)
                       + msmhd_pkg::MsgSpan), '1, '1, 0);
        while (body_q.size() < SaturatedBytes) body_q.push_back(8'($urandom));
        send_body();
        wait_results();
    endtask

    task automatic test_backpressure();
        int unsigned saved_pct;
        saved_pct   = tx_idle_pct;
        tx_idle_pct = 0;
        hold_request = 300;
        repeat (3) begin
            body_q = '{8'($urandom)};
            send_body();
        end
        build_body(pick_msg(), sparse_mask(64, 3), 32'(sparse_mask(32, 2)), 1);
        send_body();
        wait_results();
        tx_idle_pct = saved_pct;
    endtask

    task automatic run_random_bodies(input int count);
        int unsigned kind;
        int unsigned need_bytes;
        int unsigned keep;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                body_q.delete();
                repeat ($urandom_range(1, 30)) body_q.push_back(8'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    build_body(pick_msg(), {$urandom, $urandom}, $urandom,
                               $urandom_range(0, 3));
                end else begin
                    build_body(pick_msg(), sparse_mask(64, $urandom_range(0, 8)),
                               32'(sparse_mask(32, $urandom_range(0, 4))),
                               $urandom_range(0, 3));
                end
                if (kind == 2) begin
                    need_bytes = (msmhd_pkg::HdrBits + body_cells + 7) / 8;
                    if (need_bytes > msmhd_pkg::MinBytes) begin
                        keep = $urandom_range(msmhd_pkg::MinBytes, need_bytes - 1);
                    end else begin
                        keep = $urandom_range(1, msmhd_pkg::MinBytes - 1);
                    end
                    body_q = body_q[0:keep-1];
                end
            end
            send_body();
        end
    endtask

    task automatic test_random_bodies();
        tx_idle_pct = 10;
        rx_idle_pct = 74;
        run_random_bodies(PhaseBodies);
        tx_idle_pct = 74;
        rx_idle_pct = 10;
        run_random_bodies(PhaseBodies);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_bodies(PhaseBodies);
        wait_results();
    endtask

    initial begin
        tx_idle_pct = 10;
        rx_idle_pct = 74;
        clear_decoder();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_bodies();
        test_header_extremes();
        test_saturated_body();
        test_backpressure();
        test_random_bodies();
        repeat (10) @(posedge aclk);
        $display("streamed %0d bytes in %0d bodies incl. a saturating one and a long stall",
                 bytes_sent, bodies_sent);
        $display("%0d headers decoded (%0d GLONASS), %0d need-data, %0d mismatches",
                 headers_ok, glonass_ok, headers_short, mismatch_count);
        if (mismatch_count == 0) begin
            $display("msm_header_decoder: match");
        end else begin
            $display("msm_header_decoder: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_headers.size());
        $display("msm_header_decoder: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
design/msmhd_pkg.sv
design/msmhd_parse.sv
design/msm_header_decoder.sv
dv/tb_top.sv
